// ----- rtl/acs_pkg.sv -----
// Shared constants, types and alphabet functions of the affine cipher symbol unit.
`timescale 1ns / 1ps

package acs_pkg;

  // Alphabet size and the widths that follow from it.
  localparam int unsigned SYMBOL_COUNT = 67;
  localparam int unsigned IDX_W        = 7;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned PROD_W       = 13;

  // Reciprocal of the alphabet size, scaled by 2**RECIP_SHIFT and rounded down.
  // The quotient estimate is then exact or one short for sums below 8192.
  localparam int unsigned RECIP_SHIFT  = 16;
  localparam int unsigned RECIP        = (1 << RECIP_SHIFT) / SYMBOL_COUNT;
  localparam int unsigned RECIP_W      = 10;
  localparam int unsigned QPROD_W      = PROD_W + RECIP_W;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT    = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] multiplier;
    logic [IDX_W-1:0] offset;
    logic [IDX_W-1:0] inverse;
    logic             decrypt;
  } key_t;

  typedef struct packed {
    logic             member;
    logic [IDX_W-1:0] idx;
  } sym_lookup_t;

  // Reduces a 7-bit key modulo the alphabet size.
  function automatic logic [IDX_W-1:0] mod_sym(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] n;
    n = IDX_W'(SYMBOL_COUNT);
    return (x >= n) ? (x - n) : x;
  endfunction

  // Maps a byte to its alphabet position.
  function automatic sym_lookup_t sym_index(input logic [CHAR_W-1:0] c);
    sym_lookup_t res;
    res.member = 1'b1;
    res.idx    = '0;
    if (c >= 8'h61 && c <= 8'h7A) begin
      res.idx = IDX_W'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      res.idx = IDX_W'(c - 8'h41 + 8'd26);
    end else if (c >= 8'h31 && c <= 8'h39) begin
      res.idx = IDX_W'(c - 8'h31 + 8'd52);
    end else if (c == 8'h30) begin
      res.idx = 7'd61;
    end else if (c == 8'h2D) begin
      res.idx = 7'd62;
    end else if (c == 8'h2C) begin
      res.idx = 7'd63;
    end else if (c == 8'h2E) begin
      res.idx = 7'd64;
    end else if (c == 8'h28) begin
      res.idx = 7'd65;
    end else if (c == 8'h29) begin
      res.idx = 7'd66;
    end else begin
      res.member = 1'b0;
    end
    return res;
  endfunction

  // Maps an alphabet position back to its byte.
  function automatic logic [CHAR_W-1:0] sym_char(input logic [IDX_W-1:0] i);
    logic [CHAR_W-1:0] w;
    logic [CHAR_W-1:0] c;
    w = CHAR_W'(i);
    if (i < 7'd26) begin
      c = 8'h61 + w;
    end else if (i < 7'd52) begin
      c = 8'h41 + w - 8'd26;
    end else if (i < 7'd61) begin
      c = 8'h31 + w - 8'd52;
    end else if (i == 7'd61) begin
      c = 8'h30;
    end else if (i == 7'd62) begin
      c = 8'h2D;
    end else if (i == 7'd63) begin
      c = 8'h2C;
    end else if (i == 7'd64) begin
      c = 8'h2E;
    end else if (i == 7'd65) begin
      c = 8'h28;
    end else begin
      c = 8'h29;
    end
    return c;
  endfunction

endpackage

// ----- rtl/affine_cipher_67_symbol_unit.sv -----
// Top level of the affine cipher unit over the 67-symbol alphabet.
`timescale 1ns / 1ps

// Affine cipher unit over a 67-symbol alphabet: a-z, A-Z, 1-9, 0 and - , . ( ).
// The input channel (in_valid, in_stall, in_char_in) takes, unless stalled, one
// character word per cycle. A word is accepted at a rising edge with in_valid
// high and in_stall low. Encryption emits the symbol at (a*i + b) mod 67 and
// decryption the symbol at a_inv*(i - b) mod 67. A space passes through
// unchanged and a byte outside the alphabet is dropped without a result word.
// The result channel (out_valid, out_stall, out_char_out) is a register and
// throughput is one word per cycle unless the receiver stalls. The four stages
// are decode, key multiply, offset add with a reciprocal quotient estimate,
// and remainder correction with symbol lookup. When the receiver stalls a
// valid result, the whole pipeline holds and in_stall is raised in the same
// cycle, so no word is lost or repeated. Keys must be written only while idle
// over cfg_valid/cfg_ready/cfg_index/cfg_data; the unit does not enforce it,
// as cfg_ready is always high. Synchronous reset (rst_n low) empties the
// pipeline and restores multiplier 1, offset 0, inverse 1 and encrypt mode.

module affine_cipher_67_symbol_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [acs_pkg::CHAR_W-1:0]    in_char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [acs_pkg::CHAR_W-1:0]    out_char_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acs_pkg::IDX_W-1:0]     cfg_data
);
  import acs_pkg::*;

  key_t              keys_r;
  logic              en;
  logic              v1;
  logic              space1;
  logic [IDX_W-1:0]  idx1;
  logic              v3;
  logic              space3;
  logic [PROD_W-1:0] x3;
  logic [IDX_W-1:0]  q3;

  // The pipeline moves whenever the output register is free or being taken.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers hold the raw written values; reduction modulo the
  // alphabet size happens in the multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r.multiplier <= 7'd1;
      keys_r.offset     <= 7'd0;
      keys_r.inverse    <= 7'd1;
      keys_r.decrypt    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MULTIPLIER: keys_r.multiplier <= cfg_data;
        CFG_OFFSET:     keys_r.offset     <= cfg_data;
        CFG_INVERSE:    keys_r.inverse    <= cfg_data;
        CFG_DECRYPT:    keys_r.decrypt    <= cfg_data[0];
        default:        keys_r            <= keys_r;
      endcase
    end
  end

  acs_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_char  (in_char_in),
    .v1_r     (v1),
    .space1_r (space1),
    .idx1_r   (idx1)
  );

  acs_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .keys     (keys_r),
    .v1       (v1),
    .space1   (space1),
    .idx1     (idx1),
    .v3_r     (v3),
    .space3_r (space3),
    .x3_r     (x3),
    .q3_r     (q3)
  );

  acs_reduce u_reduce (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .v3          (v3),
    .space3      (space3),
    .x3          (x3),
    .q3          (q3),
    .out_valid_r (out_valid),
    .out_char_r  (out_char_out)
  );

endmodule

// ----- rtl/acs_decode.sv -----
// First pipeline stage: byte to alphabet position, dropping bytes outside the alphabet.
`timescale 1ns / 1ps

module acs_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [acs_pkg::CHAR_W-1:0] in_char,
  output logic                      v1_r,
  output logic                      space1_r,
  output logic [acs_pkg::IDX_W-1:0] idx1_r
);
  import acs_pkg::*;

  sym_lookup_t look;
  logic        is_space;
  logic        v1_nxt;

  assign look     = sym_index(in_char);
  assign is_space = (in_char == SPACE_CHAR);
  assign v1_nxt   = in_valid && (is_space || look.member);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      space1_r <= is_space;
      idx1_r   <= look.idx;
    end
  end

  // A live word is either the space or a valid alphabet position.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (space1_r || idx1_r < IDX_W'(SYMBOL_COUNT)))
    else $error("decoded position outside the alphabet");

endmodule

// ----- rtl/acs_arith.sv -----
// Second and third pipeline stages: key product, offset add and quotient estimate.
`timescale 1ns / 1ps

module acs_arith (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  acs_pkg::key_t              keys,
  input  logic                       v1,
  input  logic                       space1,
  input  logic [acs_pkg::IDX_W-1:0]  idx1,
  output logic                       v3_r,
  output logic                       space3_r,
  output logic [acs_pkg::PROD_W-1:0] x3_r,
  output logic [acs_pkg::IDX_W-1:0]  q3_r
);
  import acs_pkg::*;

  logic [IDX_W-1:0]   a_mod;
  logic [IDX_W-1:0]   b_mod;
  logic [IDX_W-1:0]   ai_mod;
  logic [CHAR_W-1:0]  diff;
  logic [IDX_W-1:0]   diff_mod;
  logic [IDX_W-1:0]   opnd;
  logic [IDX_W-1:0]   mult;
  logic [PROD_W-1:0]  p2_nxt;
  logic [IDX_W-1:0]   add2_nxt;

  logic               v2_r;
  logic               space2_r;
  logic [PROD_W-1:0]  p2_r;
  logic [IDX_W-1:0]   add2_r;

  logic [PROD_W-1:0]  x3_nxt;
  logic [QPROD_W-1:0] qprod;
  logic [IDX_W-1:0]   q3_nxt;

  assign a_mod  = mod_sym(keys.multiplier);
  assign b_mod  = mod_sym(keys.offset);
  assign ai_mod = mod_sym(keys.inverse);

  // Decryption first brings (i - b) back into the alphabet range.
  assign diff     = CHAR_W'(idx1) + CHAR_W'(SYMBOL_COUNT) - CHAR_W'(b_mod);
  assign diff_mod = (diff >= CHAR_W'(SYMBOL_COUNT)) ?
                    IDX_W'(diff - CHAR_W'(SYMBOL_COUNT)) : IDX_W'(diff);

  assign opnd     = keys.decrypt ? diff_mod : idx1;
  assign mult     = keys.decrypt ? ai_mod : a_mod;
  assign p2_nxt   = PROD_W'(mult) * PROD_W'(opnd);
  assign add2_nxt = keys.decrypt ? '0 : b_mod;

  assign x3_nxt = p2_r + PROD_W'(add2_r);
  assign qprod  = QPROD_W'(x3_nxt) * QPROD_W'(RECIP);
  assign q3_nxt = qprod[QPROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      space2_r <= space1;
      p2_r     <= p2_nxt;
      add2_r   <= add2_nxt;
      space3_r <= space2_r;
      x3_r     <= x3_nxt;
      q3_r     <= q3_nxt;
    end
  end

  // Both factors are reduced, so the product never exceeds 66 * 66.
  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !space2_r) |-> (p2_r <= PROD_W'(4356)))
    else $error("key product exceeds reduced range");

endmodule

// ----- rtl/acs_reduce.sv -----
// Fourth pipeline stage: remainder correction and alphabet lookup into the output register.
`timescale 1ns / 1ps

module acs_reduce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v3,
  input  logic                       space3,
  input  logic [acs_pkg::PROD_W-1:0] x3,
  input  logic [acs_pkg::IDX_W-1:0]  q3,
  output logic                       out_valid_r,
  output logic [acs_pkg::CHAR_W-1:0] out_char_r
);
  import acs_pkg::*;

  logic [PROD_W-1:0] qm;
  logic [PROD_W-1:0] rem;
  logic [IDX_W-1:0]  r;
  logic [CHAR_W-1:0] out_char_nxt;

  assign qm  = PROD_W'(q3) * PROD_W'(SYMBOL_COUNT);
  assign rem = x3 - qm;
  // The quotient estimate is at most one short, so one subtraction finishes.
  assign r   = (rem >= PROD_W'(SYMBOL_COUNT)) ?
               IDX_W'(rem - PROD_W'(SYMBOL_COUNT)) : IDX_W'(rem);
  assign out_char_nxt = space3 ? SPACE_CHAR : sym_char(r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_char_r <= out_char_nxt;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v3 && !space3) |-> (rem < PROD_W'(2 * SYMBOL_COUNT)))
    else $error("quotient estimate off by more than one");

  a_space_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3 && space3) |=> (out_valid_r && out_char_r == SPACE_CHAR))
    else $error("space word was not passed through");

endmodule
